[sv/bdmrs_pkg.sv]
// Package for the block-decomposed modular range-sum unit.
// Holds the modulus, field widths, request and register codes and the sequencer state type.
// No dependencies.
package bdmrs_pkg;

	// Modulus of all residues.
	localparam logic [29:0] RESIDUE_MOD = 30'd998244353;

	// Fixed field widths.
	localparam int VAL_W  = 30;
	localparam int IDX_W  = 12;
	localparam int KIND_W = 2;

	// Request codes carried on s_tuser.
	localparam logic [KIND_W-1:0] REQ_POINT_ADD = 2'd0;
	localparam logic [KIND_W-1:0] REQ_RANGE_ADD = 2'd1;
	localparam logic [KIND_W-1:0] REQ_QUERY     = 2'd2;

	// Configuration register map.
	localparam logic [2:0]       ADDR_ACTIVE_SIZE  = 3'd0;
	localparam logic [IDX_W-1:0] ACTIVE_SIZE_RESET = 12'd4095;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_ADD_RD,
		ST_ADD_WE,
		ST_ADD_WB,
		ST_MARK2,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

[sv/bdmrs_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the element store and the block sums. No dependencies.
module bdmrs_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/bdmrs_modadd.sv]
// Shared modular adder: one wide add followed by one compare and subtract.
// Depends on bdmrs_pkg for the modulus.
module bdmrs_modadd
	import bdmrs_pkg::*;
(
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	output logic [VAL_W-1:0] y
);

	logic [VAL_W:0] sum;

	// The sum of the operands stays below twice the modulus, so one correction suffices.
	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, RESIDUE_MOD}) begin
			y = VAL_W'(sum - {1'b0, RESIDUE_MOD});
		end else begin
			y = sum[VAL_W-1:0];
		end
	end

endmodule

[sv/block_decomposed_modular_range_sum_unit.sv]
// Block-decomposed modular range-sum unit: element store plus one sum per block of BLOCK.
// A point add divides the index by BLOCK, then reads, updates and writes back the element
// and its block sum; a range add may repeat this for the end mark at hi + 1, a query walks
// elements and block sums, and empty or unused requests go straight to the result beat.
// s_tready is high only when idle; a stalled result beat holds the next one back. Reset is
// asynchronous, active low; a clearing pass zeroes both stores before any beat is taken.
module block_decomposed_modular_range_sum_unit
	import bdmrs_pkg::*;
#(
	parameter int ELEMENTS = 4096,
	parameter int BLOCK    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // lo_index[11:0], hi_index[23:12], add_value[53:24], zero
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // range_sum[29:0], zero
	output logic [0:0]  m_tuser,   // was_query[0]
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW  = $clog2(ELEMENTS);
	localparam int GN  = (ELEMENTS + BLOCK - 1) / BLOCK;
	localparam int GW  = (GN > 1) ? $clog2(GN) : 1;
	localparam int WW  = (AW + 1 > IDX_W + 2) ? AW + 1 : IDX_W + 2;
	localparam int RW  = $clog2(BLOCK) + 1;
	localparam int CW  = 1;
	localparam int DIV_SH = WW + $clog2(BLOCK);
	localparam int MW  = WW + 2;
	localparam int PW  = WW + MW;
	localparam logic [WW-1:0] ELEM_W    = WW'(ELEMENTS);
	localparam logic [WW-1:0] ELEM_LAST = WW'(ELEMENTS - 1);
	localparam logic [AW-1:0] CLR_LAST  = AW'(ELEMENTS - 1);
	localparam logic [RW-1:0] OFS_LAST  = RW'(BLOCK - 1);
	localparam logic [WW-1:0] BLOCK_M1  = WW'(BLOCK - 1);
	localparam logic [WW-1:0] BLOCK_W   = WW'(BLOCK);
	localparam logic [CW-1:0] DIV_LAST  = CW'(1);
	localparam logic [MW-1:0] DIV_M     = MW'((1 << DIV_SH) / BLOCK + 1);

	state_t state_q, state_d;

	// Input fields.
	logic [KIND_W-1:0] s_kind;
	logic [IDX_W-1:0]  s_lo, s_hi;
	logic [VAL_W-1:0]  s_add_value;
	assign s_kind      = s_tuser;
	assign s_lo        = s_tdata[11:0];
	assign s_hi        = s_tdata[23:12];
	assign s_add_value = s_tdata[53:24];

	// Control and datapath registers.
	logic [AW-1:0]     clr_q;
	logic [IDX_W-1:0]  act_q;
	logic [KIND_W-1:0] kind_q;
	logic [WW-1:0]     hi_q, tgt_q, num_q, i_q;
	logic [VAL_W-1:0]  val_q, addv_q, acc_q, res_sum_q, m_sum_q;
	logic              res_flag_q, m_flag_q, m_tvalid_q, second_q;
	logic [RW-1:0]     r_q;
	logic [CW-1:0]     cnt_q;
	logic [GW-1:0]     g_q;
	logic              pend_q, pend_blk_q;

	// RAM ports and the shared adder.
	logic              e_we, b_we;
	logic [AW-1:0]     e_waddr, e_raddr;
	logic [GW-1:0]     b_waddr, b_raddr;
	logic [VAL_W-1:0]  e_wdata, b_wdata, e_rdata, b_rdata;
	logic [VAL_W-1:0]  ua, ub, uy;

	bdmrs_ram #(.WIDTH(VAL_W), .DEPTH(ELEMENTS)) u_elem_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	bdmrs_ram #(.WIDTH(VAL_W), .DEPTH(GN)) u_block_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	bdmrs_modadd u_add (.a(ua), .b(ub), .y(uy));

	// Decode of the incoming beat.
	logic [WW-1:0] s_lo_w, s_hi_w, s_hi_c;
	logic          s_lo_ok;
	assign s_lo_w  = WW'(s_lo);
	assign s_hi_w  = WW'(s_hi);
	assign s_hi_c  = (s_hi_w > ELEM_LAST) ? ELEM_LAST : s_hi_w;
	assign s_lo_ok = s_lo_w < ELEM_W;

	// End mark of a range add and its negated value.
	logic [WW-1:0]    hi_inc;
	logic             mark2_ok;
	logic [VAL_W-1:0] neg_val;
	assign hi_inc   = hi_q + WW'(1);
	assign mark2_ok = (hi_q[IDX_W-1:0] < act_q) && (hi_inc < ELEM_W);
	assign neg_val  = (val_q == '0) ? '0 : RESIDUE_MOD - val_q;

	// Division by BLOCK: first the quotient by multiplying with a scaled reciprocal,
	// then the offset by subtracting the quotient times BLOCK from the index.
	logic [PW-1:0] div_prod;
	logic [WW-1:0] div_quo, div_back, div_rem;
	logic          div_last;
	assign div_prod = {{MW{1'b0}}, num_q} * {{WW{1'b0}}, DIV_M};
	assign div_quo  = WW'(div_prod >> DIV_SH);
	assign div_back = num_q * BLOCK_W;
	assign div_rem  = tgt_q - div_back;
	assign div_last = cnt_q == DIV_LAST;

	// Walk decisions: whole block sum where aligned and fully covered, else one element.
	logic walk_more, blk_step, ofs_wrap;
	assign walk_more = i_q <= hi_q;
	assign blk_step  = (r_q == '0) && ((i_q + BLOCK_M1) <= hi_q);
	assign ofs_wrap  = r_q == OFS_LAST;

	logic out_free, clr_in_groups;
	assign out_free      = !m_tvalid_q || m_tready;
	assign clr_in_groups = {1'b0, clr_q} < (AW + 1)'(GN);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM control and adder operand selection.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		e_we     = 1'b0;
		e_waddr  = tgt_q[AW-1:0];
		e_wdata  = uy;
		e_raddr  = tgt_q[AW-1:0];
		b_we     = 1'b0;
		b_waddr  = g_q;
		b_wdata  = uy;
		b_raddr  = g_q;
		ua       = '0;
		ub       = '0;
		case (state_q)
			ST_CLEAR: begin
				e_we    = 1'b1;
				e_waddr = clr_q;
				e_wdata = '0;
				b_we    = clr_in_groups;
				b_waddr = clr_q[GW-1:0];
				b_wdata = '0;
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				ua       = s_add_value;
				if (s_tvalid) begin
					case (s_kind)
						REQ_POINT_ADD: state_d = s_lo_ok ? ST_DIV : ST_FINISH;
						REQ_RANGE_ADD: begin
							if (s_lo > s_hi) begin
								state_d = ST_FINISH;
							end else begin
								state_d = s_lo_ok ? ST_DIV : ST_MARK2;
							end
						end
						REQ_QUERY: state_d = (s_lo_w > s_hi_c) ? ST_FINISH : ST_DIV;
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = (kind_q == REQ_QUERY) ? ST_WALK : ST_ADD_RD;
				end
			end
			ST_ADD_RD: state_d = ST_ADD_WE;
			ST_ADD_WE: begin
				ua      = e_rdata;
				ub      = addv_q;
				e_we    = 1'b1;
				state_d = ST_ADD_WB;
			end
			ST_ADD_WB: begin
				ua   = b_rdata;
				ub   = addv_q;
				b_we = 1'b1;
				if (kind_q == REQ_RANGE_ADD && !second_q) begin
					state_d = ST_MARK2;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_MARK2: state_d = mark2_ok ? ST_DIV : ST_FINISH;
			ST_WALK: begin
				ua      = acc_q;
				ub      = pend_blk_q ? b_rdata : e_rdata;
				e_raddr = i_q[AW-1:0];
				if (!walk_more && !pend_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_SIZE_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_SIZE) begin
			act_q <= pwdata[IDX_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ACTIVE_SIZE) ? {20'd0, act_q} : 32'd0;

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE, ST_MARK2: cnt_q <= '0;
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (div_last) begin
						pend_q <= 1'b0;
					end
				end
				ST_WALK: pend_q <= walk_more;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					kind_q     <= s_kind;
					hi_q       <= (s_kind == REQ_QUERY) ? s_hi_c : s_hi_w;
					val_q      <= uy;
					addv_q     <= uy;
					second_q   <= 1'b0;
					tgt_q      <= s_lo_w;
					num_q      <= s_lo_w;
					res_sum_q  <= '0;
					res_flag_q <= (s_kind == REQ_QUERY);
				end
			end
			ST_MARK2: begin
				second_q <= 1'b1;
				tgt_q    <= hi_inc;
				num_q    <= hi_inc;
				addv_q   <= neg_val;
			end
			ST_DIV: begin
				if (div_last) begin
					g_q   <= num_q[GW-1:0];
					r_q   <= div_rem[RW-1:0];
					i_q   <= tgt_q;
					acc_q <= '0;
				end else begin
					num_q <= div_quo;
				end
			end
			ST_WALK: begin
				if (pend_q) begin
					acc_q <= uy;
				end
				if (walk_more) begin
					pend_blk_q <= blk_step;
					if (blk_step) begin
						i_q <= i_q + BLOCK_W;
						g_q <= g_q + GW'(1);
					end else begin
						i_q <= i_q + WW'(1);
						r_q <= ofs_wrap ? '0 : r_q + RW'(1);
						if (ofs_wrap) begin
							g_q <= g_q + GW'(1);
						end
					end
				end else if (!pend_q) begin
					res_sum_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_sum_q  <= res_sum_q;
			m_flag_q <= res_flag_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_sum_q};
	assign m_tuser  = m_flag_q;

endmodule

[sv/bdmrs_checker.sv]
// Port-level assertions for the block-decomposed modular range-sum unit, and their bind.
// Depends on bdmrs_pkg for the modulus.
module bdmrs_checker
	import bdmrs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Update acknowledgements always carry a zero sum.
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("acknowledgement with nonzero sum");

	// Every sum is a reduced residue.
	a_sum_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata < {2'b00, RESIDUE_MOD})
		else $error("sum not reduced modulo the residue modulus");

	// After a request is taken the unit is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request accepted back to back");

endmodule

bind block_decomposed_modular_range_sum_unit bdmrs_checker u_bdmrs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

[dv/block_decomposed_modular_range_sum_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_decomposed_modular_range_sum_unit.
// Keeps its own copy of the element and block-sum stores and checks every result beat.
// Depends on bdmrs_pkg and the unit itself.
module block_decomposed_modular_range_sum_unit_tb
	import bdmrs_pkg::*;
();

	localparam int N_ELEM       = 4096;
	localparam int BLK          = 64;
	localparam int N_BLK        = (N_ELEM + BLK - 1) / BLK;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;

	localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0]  MAX_RES    = RESIDUE_MOD - 30'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [VAL_W-1:0]  val;
	} range_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] sum;
		logic             was_query;
	} sum_result_t;

	// Clock, reset and the block's inputs, all known from time zero.
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;   // lo_index[11:0], hi_index[23:12], add_value[53:24], zero
	logic [1:0]  s_tuser  = '0;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // range_sum[29:0], zero
	logic [0:0]  m_tuser;         // was_query[0]
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the unit's stores and its register.
	logic [VAL_W-1:0] elem_model  [0:N_ELEM-1] = '{default: '0};
	logic [VAL_W-1:0] block_model [0:N_BLK-1]  = '{default: '0};
	logic [IDX_W-1:0] model_active = ACTIVE_SIZE_RESET;

	range_req_t  pending_reqs[$];
	sum_result_t expected_sums[$];
	range_req_t  bus_req;

	int  tx_gap       = 0;
	int  rx_gap       = 0;
	int  hold_cnt     = 0;
	bit  no_idle      = 1'b0;
	bit  hold_armed   = 1'b0;
	bit  hold_done    = 1'b0;
	int  err_cnt      = 0;
	int  query_cnt    = 0;
	int  ack_cnt      = 0;
	int  cfg_writes   = 0;
	int  cycle_cnt    = 0;

	block_decomposed_modular_range_sum_unit #(
		.ELEMENTS(N_ELEM),
		.BLOCK   (BLK)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Modular addition of two residues.
	function automatic logic [VAL_W-1:0] mod_sum(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, RESIDUE_MOD})
			s = s - {1'b0, RESIDUE_MOD};
		return s[VAL_W-1:0];
	endfunction

	// Adds a residue to one element and to its block sum; indices past the store are dropped.
	function automatic void store_add(int idx, logic [VAL_W-1:0] v);
		if (idx >= N_ELEM)
			return;
		elem_model[idx]      = mod_sum(elem_model[idx], v);
		block_model[idx/BLK] = mod_sum(block_model[idx/BLK], v);
	endfunction

	// Sum over lo..hi, whole blocks taken from the block sums.
	function automatic logic [VAL_W-1:0] range_total(int lo, int hi);
		logic [VAL_W-1:0] acc;
		int i;
		acc = '0;
		if (hi >= N_ELEM)
			hi = N_ELEM - 1;
		if (lo > hi)
			return '0;
		i = lo;
		while (i <= hi) begin
			if ((i % BLK) == 0 && i + BLK - 1 <= hi) begin
				acc = mod_sum(acc, block_model[i/BLK]);
				i += BLK;
			end else begin
				acc = mod_sum(acc, elem_model[i]);
				i++;
			end
		end
		return acc;
	endfunction

	// Applies one accepted request to the shadow stores and returns its result beat.
	function automatic sum_result_t apply_request(range_req_t q);
		sum_result_t r;
		logic [VAL_W-1:0] v;
		int lo_i;
		int hi_i;
		r    = '0;
		v    = q.val % RESIDUE_MOD;
		lo_i = q.lo;
		hi_i = q.hi;
		case (q.kind)
			REQ_POINT_ADD: begin
				store_add(lo_i, v);
			end
			REQ_RANGE_ADD: begin
				if (lo_i <= hi_i) begin
					store_add(lo_i, v);
					if (hi_i < int'(model_active))
						store_add(hi_i + 1, (v == '0) ? '0 : RESIDUE_MOD - v);
				end
			end
			REQ_QUERY: begin
				r.sum       = range_total(lo_i, hi_i);
				r.was_query = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Random request, mostly well-formed ranges with the odd empty range or unused code.
	function automatic range_req_t random_req();
		range_req_t q;
		int pick;
		int lo_i;
		int hi_i;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			q.kind = REQ_UNUSED;
		else if (pick < 38)
			q.kind = REQ_POINT_ADD;
		else if (pick < 68)
			q.kind = REQ_RANGE_ADD;
		else
			q.kind = REQ_QUERY;
		lo_i = $urandom_range(0, N_ELEM - 1);
		case ($urandom_range(0, 4))
			0: hi_i = $urandom_range(0, N_ELEM - 1);
			1: hi_i = lo_i + int'($urandom_range(0, 150));
			2: begin
				lo_i = int'($urandom_range(0, N_BLK - 1)) * BLK;
				hi_i = lo_i + int'($urandom_range(1, 6)) * BLK - 1;
			end
			3: hi_i = lo_i - int'($urandom_range(1, 20));
			default: begin
				// Ends near the active size, where the end mark starts or stops being placed.
				hi_i = int'(model_active) - 1 + int'($urandom_range(0, 2));
				lo_i = hi_i - int'($urandom_range(0, 100));
			end
		endcase
		if (hi_i > N_ELEM - 1)
			hi_i = N_ELEM - 1;
		if (hi_i < 0)
			hi_i = 0;
		if (lo_i < 0)
			lo_i = 0;
		q.lo = lo_i[IDX_W-1:0];
		q.hi = hi_i[IDX_W-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 5)
			q.val = '0;
		else if (pick < 10)
			q.val = MAX_RES;
		else if (pick < 20)
			q.val = VAL_W'($urandom_range(32'(RESIDUE_MOD), 32'h3FFF_FFFF));
		else
			q.val = VAL_W'($urandom_range(0, 32'(MAX_RES)));
		return q;
	endfunction

	// Request driver: holds a beat until taken, then idles or offers the next one.
	always @(posedge clk) begin : request_driver
		range_req_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_sums = {expected_sums, apply_request(bus_req)};
			if (s_tvalid && !s_tready) begin
				// Beat still waiting; leave the bus alone.
			end else if (tx_gap > 0) begin
				tx_gap   <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				bus_req  <= next_req;
				s_tdata  <= {2'b00, next_req.val, next_req.hi, next_req.lo};
				s_tuser  <= next_req.kind;
				s_tvalid <= 1'b1;
				tx_gap   <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: checks each beat against the oldest expectation and throttles m_tready.
	always @(posedge clk) begin : result_monitor
		sum_result_t want;
		int gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			gap = rx_gap;
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result beat, range_sum %0d was_query %0d",
						$time, m_tdata[VAL_W-1:0], m_tuser[0]);
				end else begin
					want = expected_sums.pop_front();
					if (m_tdata[VAL_W-1:0] !== want.sum) begin
						err_cnt++;
						$display("%0t: range_sum mismatch, expected %0d, got %0d",
							$time, want.sum, m_tdata[VAL_W-1:0]);
					end
					if (m_tuser[0] !== want.was_query) begin
						err_cnt++;
						$display("%0t: was_query mismatch, expected %0d, got %0d",
							$time, want.was_query, m_tuser[0]);
					end
					if (want.was_query)
						query_cnt++;
					else
						ack_cnt++;
				end
				gap = pick_gap();
			end
			if (hold_armed && !hold_done) begin
				// Long hold-off so the unit backs up and stalls its input.
				m_tready <= 1'b0;
				hold_cnt <= hold_cnt + 1;
				if (hold_cnt == HOLD_CYCLES - 1)
					hold_done <= 1'b1;
				rx_gap <= 0;
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				rx_gap   <= gap - 1;
			end else begin
				m_tready <= 1'b1;
				rx_gap   <= 0;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_cnt, expected_sums.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Writes active_size over the configuration port, mirrors it in the model and reads it back.
	task automatic write_active_size(input logic [IDX_W-1:0] size);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ACTIVE_SIZE;
		pwdata  <= {20'd0, size};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		model_active = size;
		cfg_writes++;
		if (prdata !== {20'd0, size}) begin
			err_cnt++;
			$display("%0t: active_size readback mismatch, expected %0d, got %0d",
				$time, size, prdata);
		end
	endtask

	// Sender pause: nothing queued, nothing on the bus, nothing expected.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_sums.size() != 0);
	endtask

	task automatic queue_req(input logic [KIND_W-1:0] kind, input int lo, input int hi,
			input logic [VAL_W-1:0] val);
		range_req_t q;
		q.kind = kind;
		q.lo   = lo[IDX_W-1:0];
		q.hi   = hi[IDX_W-1:0];
		q.val  = val;
		pending_reqs = {pending_reqs, q};
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			pending_reqs = {pending_reqs, random_req()};
	endtask

	// Main sequence.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_active_size(12'd4095);

		// Directed: field extremes, every request code and the corner cases.
		queue_req(REQ_POINT_ADD, 0, 0, MAX_RES);
		queue_req(REQ_POINT_ADD, 4095, 4095, 30'h3FFF_FFFF);
		queue_req(REQ_POINT_ADD, 63, 0, RESIDUE_MOD);
		queue_req(REQ_RANGE_ADD, 10, 200, 30'd12345);
		queue_req(REQ_RANGE_ADD, 4094, 4095, 30'd7);
		queue_req(REQ_RANGE_ADD, 4095, 4094, 30'd5);
		queue_req(REQ_RANGE_ADD, 0, 0, 30'd0);
		queue_req(REQ_RANGE_ADD, 64, 127, MAX_RES);
		queue_req(REQ_QUERY, 0, 4095, 30'h3FFF_FFFF);
		queue_req(REQ_QUERY, 0, 63, 30'd0);
		queue_req(REQ_QUERY, 1, 62, 30'd0);
		queue_req(REQ_QUERY, 5, 5, 30'd0);
		queue_req(REQ_QUERY, 100, 99, 30'd0);
		queue_req(REQ_QUERY, 4095, 4095, 30'd0);
		queue_req(REQ_QUERY, 63, 128, 30'd0);
		queue_req(REQ_UNUSED, 1, 2, 30'h3FFF_FFFF);
		queue_req(REQ_POINT_ADD, 2048, 4095, 30'd1);
		queue_req(REQ_RANGE_ADD, 0, 4094, 30'd1000);
		queue_req(REQ_QUERY, 0, 4095, 30'd0);
		queue_req(REQ_QUERY, 4000, 4095, 30'd0);
		queue_req(REQ_QUERY, 4095, 0, 30'd0);
		wait_drained();

		queue_random(300);
		wait_drained();

		write_active_size(12'd1);
		queue_random(250);
		wait_drained();

		// Back-to-back stretch with no idling on either side.
		write_active_size(12'd2048);
		no_idle = 1'b1;
		queue_random(200);
		wait_drained();
		no_idle = 1'b0;

		// Receiver holds off while the sender keeps offering beats.
		hold_armed = 1'b1;
		queue_random(60);
		do
			@(negedge clk);
		while (!hold_done);
		wait_drained();

		write_active_size(IDX_W'($urandom_range(1, 4095)));
		queue_random(250);
		wait_drained();

		write_active_size(12'd64);
		queue_random(70);
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Checked %0d query sums and %0d update acknowledgements", query_cnt, ack_cnt);
		$display("across %0d active_size settings, with a %0d-cycle receiver hold-off.",
			cfg_writes, HOLD_CYCLES);
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
